@@ src/qpms_pkg.sv @@
// Package for the quadrotor point-mass step block.
// Holds item types, fixed-point widths, the CORDIC angle table and rounding helpers.
// No dependencies.
`default_nettype none
package qpms_pkg;

  localparam int TRIG_ANGLE_BITS = 16;
  localparam int STATE_WIDTH = 32;

  localparam logic [15:0] ANGLE_MASK =
    (TRIG_ANGLE_BITS >= 16) ? 16'hFFFF : 16'(16'hFFFF << (16 - TRIG_ANGLE_BITS));

  localparam int MUL_A_W = (STATE_WIDTH > 32) ? STATE_WIDTH : 32;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int WIDE_W = MUL_P_W + 2;

  localparam int CFG_GRAVITY = 0;
  localparam int CFG_TIME_STEP = 1;
  localparam int CFG_ACCEL = 2;
  localparam int CFG_START_X = 3;
  localparam int CFG_START_Y = 4;
  localparam int CFG_START_Z = 5;

  typedef struct packed {
    logic signed [15:0] throttle;
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic on_ground;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;
  } trig_res_t;

  function automatic logic [13:0] atan_at(input logic [3:0] i);
    logic [13:0] r;
    case (i)
      4'd0: r = 14'd8192;
      4'd1: r = 14'd4836;
      4'd2: r = 14'd2555;
      4'd3: r = 14'd1297;
      4'd4: r = 14'd651;
      4'd5: r = 14'd326;
      4'd6: r = 14'd163;
      4'd7: r = 14'd81;
      4'd8: r = 14'd41;
      4'd9: r = 14'd20;
      4'd10: r = 14'd10;
      4'd11: r = 14'd5;
      4'd12: r = 14'd3;
      4'd13: r = 14'd1;
      4'd14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd_shift(
    input logic signed [WIDE_W-1:0] v, input int n);
    logic signed [WIDE_W-1:0] h;
    h = WIDE_W'(1) <<< (n - 1);
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_w(
    input logic signed [WIDE_W-1:0] v, input int w);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) <<< (w - 1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/qpms_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on qpms_pkg for operand widths.
`default_nettype none
module qpms_mul (
  input wire logic clk,
  input wire logic signed [qpms_pkg::MUL_A_W-1:0] a,
  input wire logic signed [qpms_pkg::MUL_B_W-1:0] b,
  output logic signed [qpms_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= qpms_pkg::MUL_P_W'(a) * qpms_pkg::MUL_P_W'(b);
  end

endmodule
`default_nettype wire

@@ src/qpms_cordic.sv @@
// Iterative CORDIC giving Q1.14 sine and cosine of a 16-bit turn angle, one step a cycle.
// Depends on qpms_pkg for the angle table and result type.
`default_nettype none
module qpms_cordic (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [15:0] angle,
  output qpms_pkg::trig_res_t res
);

  logic signed [27:0] x;
  logic signed [27:0] y;
  logic signed [17:0] z;
  logic [3:0] iter;
  logic [1:0] quad;
  logic busy;
  logic done;

  logic [15:0] ang_m;
  logic [15:0] ang_q;
  logic [1:0] quad_next;
  logic signed [27:0] dx;
  logic signed [27:0] dy;
  logic signed [17:0] at;
  logic signed [27:0] xr;
  logic signed [27:0] yr;
  logic signed [15:0] cs;
  logic signed [15:0] sn;

  always_comb begin
    ang_m = angle & qpms_pkg::ANGLE_MASK;
    ang_q = ang_m + 16'd8192;
    quad_next = ang_q[15:14];
    dx = y >>> iter;
    dy = x >>> iter;
    at = 18'(qpms_pkg::atan_at(iter));
    xr = (x + 28'sd512) >>> 10;
    yr = (y + 28'sd512) >>> 10;
    if (xr > 28'sd16384) begin
      cs = 16'sd16384;
    end else if (xr < -28'sd16384) begin
      cs = -16'sd16384;
    end else begin
      cs = 16'(xr);
    end
    if (yr > 28'sd16384) begin
      sn = 16'sd16384;
    end else if (yr < -28'sd16384) begin
      sn = -16'sd16384;
    end else begin
      sn = 16'(yr);
    end
    res.done = done;
    case (quad)
      2'd0: begin
        res.cos_val = cs;
        res.sin_val = sn;
      end
      2'd1: begin
        res.cos_val = -sn;
        res.sin_val = cs;
      end
      2'd2: begin
        res.cos_val = -cs;
        res.sin_val = -sn;
      end
      default: begin
        res.cos_val = sn;
        res.sin_val = -cs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        quad <= quad_next;
        x <= 28'sd10187910;
        y <= '0;
        z <= 18'(signed'(ang_m - {quad_next, 14'd0}));
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        iter <= iter + 4'd1;
        if (iter == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/quadrotor_point_mass_step.sv @@
// Top level of the quadrotor point-mass step: sequencer, state and configuration.
// Depends on qpms_pkg, qpms_cordic and qpms_mul.
`default_nettype none
// One item is one dynamics tick. A restart item loads the start position and goes straight to
// the output state, which makes the result valid. Any other item runs three CORDIC passes
// for roll, pitch and yaw, then 20 sequencer steps that feed the one shared multiplier for
// thrust axis, acceleration and integration, then the output state loads the result. The
// ground clamp can end the sequence after the acceleration steps, skipping integration.
// A new item is taken only once the previous result has been taken.
module quadrotor_point_mass_step (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire qpms_pkg::in_item_t in_item,
  output logic out_valid,
  input wire logic out_ready,
  output qpms_pkg::out_item_t out_item,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [31:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRIG = 2'd1;
  localparam logic [1:0] S_MATH = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;
  localparam int SW = qpms_pkg::STATE_WIDTH;
  localparam int WW = qpms_pkg::WIDE_W;
  localparam int AW = qpms_pkg::MUL_A_W;
  localparam int BW = qpms_pkg::MUL_B_W;

  logic [1:0] state;
  logic [4:0] step;
  logic [1:0] trig_idx;
  logic trig_start;

  logic [22:0] gravity;
  logic [16:0] time_step;
  logic [24:0] accel_per_throttle;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;

  qpms_pkg::in_item_t item;
  logic signed [SW-1:0] px, py, pz, vx, vy, vz;
  logic ground;

  logic signed [15:0] sr, cr, sp, cp, sy, cy;
  logic signed [29:0] t1;
  logic signed [47:0] acc;
  logic signed [16:0] tx, ty, tz;
  logic signed [26:0] a;
  logic signed [28:0] ax, ay, az;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [qpms_pkg::MUL_P_W-1:0] prod;
  logic signed [WW-1:0] pw;
  logic signed [WW-1:0] accw;
  logic signed [WW-1:0] dtr;
  logic [15:0] trig_angle;
  qpms_pkg::trig_res_t trig;

  qpms_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .start(trig_start),
    .angle(trig_angle),
    .res(trig)
  );

  qpms_mul u_mul (
    .clk(clk),
    .a(mul_a),
    .b(mul_b),
    .p(prod)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    pw = WW'(prod);
    accw = WW'(acc);
    dtr = qpms_pkg::rnd_shift(pw, 16);
    case (trig_idx)
      2'd0: trig_angle = item.roll_angle;
      2'd1: trig_angle = item.pitch_angle;
      default: trig_angle = item.yaw_angle;
    endcase
    mul_a = '0;
    mul_b = '0;
    case (step)
      5'd0: begin
        mul_a = AW'(cy);
        mul_b = BW'(sp);
      end
      5'd1: begin
        mul_a = AW'(sy);
        mul_b = BW'(sr);
      end
      5'd2: begin
        mul_a = AW'(t1);
        mul_b = BW'(cr);
      end
      5'd3: begin
        mul_a = AW'(sy);
        mul_b = BW'(sp);
      end
      5'd4: begin
        mul_a = AW'(cy);
        mul_b = BW'(sr);
      end
      5'd5: begin
        mul_a = AW'(t1);
        mul_b = BW'(cr);
      end
      5'd6: begin
        mul_a = AW'(cp);
        mul_b = BW'(cr);
      end
      5'd7: begin
        mul_a = AW'(signed'({1'b0, accel_per_throttle}));
        mul_b = BW'(item.throttle);
      end
      5'd9: begin
        mul_a = AW'(a);
        mul_b = BW'(tx);
      end
      5'd10: begin
        mul_a = AW'(a);
        mul_b = BW'(ty);
      end
      5'd11: begin
        mul_a = AW'(a);
        mul_b = BW'(tz);
      end
      5'd13: begin
        mul_a = AW'(ax);
        mul_b = BW'(signed'({1'b0, time_step}));
      end
      5'd14: begin
        mul_a = AW'(ay);
        mul_b = BW'(signed'({1'b0, time_step}));
      end
      5'd15: begin
        mul_a = AW'(az);
        mul_b = BW'(signed'({1'b0, time_step}));
      end
      5'd16: begin
        mul_a = AW'(vx);
        mul_b = BW'(signed'({1'b0, time_step}));
      end
      5'd17: begin
        mul_a = AW'(vy);
        mul_b = BW'(signed'({1'b0, time_step}));
      end
      5'd18: begin
        mul_a = AW'(vz);
        mul_b = BW'(signed'({1'b0, time_step}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= 23'd642253;
      time_step <= 17'd1311;
      accel_per_throttle <= 25'd3211264;
      start_x <= '0;
      start_y <= '0;
      start_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        3'(qpms_pkg::CFG_GRAVITY): gravity <= cfg_data[22:0];
        3'(qpms_pkg::CFG_TIME_STEP): time_step <= cfg_data[16:0];
        3'(qpms_pkg::CFG_ACCEL): accel_per_throttle <= cfg_data[24:0];
        3'(qpms_pkg::CFG_START_X): start_x <= cfg_data;
        3'(qpms_pkg::CFG_START_Y): start_y <= cfg_data;
        3'(qpms_pkg::CFG_START_Z): start_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      trig_idx <= '0;
      trig_start <= 1'b0;
      out_valid <= 1'b0;
      px <= '0;
      py <= '0;
      pz <= '0;
      vx <= '0;
      vy <= '0;
      vz <= '0;
      ground <= 1'b0;
    end else begin
      trig_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_item;
            ground <= 1'b0;
            if (in_item.restart) begin
              px <= SW'(qpms_pkg::sat_w(WW'(start_x), SW));
              py <= SW'(qpms_pkg::sat_w(WW'(start_y), SW));
              pz <= SW'(qpms_pkg::sat_w(WW'(start_z), SW));
              vx <= '0;
              vy <= '0;
              vz <= '0;
              state <= S_OUT;
            end else begin
              trig_idx <= '0;
              trig_start <= 1'b1;
              state <= S_TRIG;
            end
          end
        end
        S_TRIG: begin
          if (trig.done) begin
            case (trig_idx)
              2'd0: begin
                sr <= trig.sin_val;
                cr <= trig.cos_val;
              end
              2'd1: begin
                sp <= trig.sin_val;
                cp <= trig.cos_val;
              end
              default: begin
                sy <= trig.sin_val;
                cy <= trig.cos_val;
              end
            endcase
            if (trig_idx == 2'd2) begin
              step <= '0;
              state <= S_MATH;
            end else begin
              trig_idx <= trig_idx + 2'd1;
              trig_start <= 1'b1;
            end
          end
        end
        S_MATH: begin
          step <= step + 5'd1;
          case (step)
            5'd1: t1 <= 30'(prod);
            5'd2: acc <= 48'(pw <<< 14);
            5'd3: acc <= acc + 48'(pw);
            5'd4: begin
              tx <= 17'(qpms_pkg::rnd_shift(accw, 28));
              t1 <= 30'(prod);
            end
            5'd5: acc <= 48'(-(pw <<< 14));
            5'd6: acc <= acc + 48'(pw);
            5'd7: begin
              ty <= 17'(qpms_pkg::rnd_shift(accw, 28));
              tz <= 17'(qpms_pkg::rnd_shift(pw, 14));
            end
            5'd8: a <= 27'(qpms_pkg::rnd_shift(pw, 14));
            5'd10: ax <= 29'(qpms_pkg::rnd_shift(pw, 14));
            5'd11: ay <= 29'(qpms_pkg::rnd_shift(pw, 14));
            5'd12: az <= 29'(qpms_pkg::rnd_shift(pw, 14) - WW'(gravity));
            5'd13: begin
              if (pz <= 0 && az <= 0) begin
                pz <= '0;
                ground <= 1'b1;
                state <= S_OUT;
              end
            end
            5'd14: vx <= SW'(qpms_pkg::sat_w(WW'(vx) + dtr, SW));
            5'd15: vy <= SW'(qpms_pkg::sat_w(WW'(vy) + dtr, SW));
            5'd16: vz <= SW'(qpms_pkg::sat_w(WW'(vz) + dtr, SW));
            5'd17: px <= SW'(qpms_pkg::sat_w(WW'(px) + dtr, SW));
            5'd18: py <= SW'(qpms_pkg::sat_w(WW'(py) + dtr, SW));
            5'd19: begin
              pz <= SW'(qpms_pkg::sat_w(WW'(pz) + dtr, SW));
              state <= S_OUT;
            end
            default: ;
          endcase
        end
        default: begin
          out_item.pos_x <= 32'(qpms_pkg::sat_w(WW'(px), 32));
          out_item.pos_y <= 32'(qpms_pkg::sat_w(WW'(py), 32));
          out_item.pos_z <= 32'(qpms_pkg::sat_w(WW'(pz), 32));
          out_item.vel_x <= 32'(qpms_pkg::sat_w(WW'(vx), 32));
          out_item.vel_y <= 32'(qpms_pkg::sat_w(WW'(vy), 32));
          out_item.vel_z <= 32'(qpms_pkg::sat_w(WW'(vz), 32));
          out_item.on_ground <= ground;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ dv/quadrotor_point_mass_step_tb.sv @@
// Testbench for quadrotor_point_mass_step: drives dynamics ticks and config writes,
// predicts position, velocity and ground flag per tick, and compares each result.
// Depends on qpms_pkg and the quadrotor_point_mass_step RTL.
`timescale 1ns / 1ps
module quadrotor_point_mass_step_tb;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  qpms_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  qpms_pkg::out_item_t out_item;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  quadrotor_point_mass_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int NUM_RANDOM = 1870;
  localparam int WATCHDOG_LIMIT = 20000;

  longint pos_st[3];
  longint vel_st[3];
  longint grav_r, dt_r, accel_r, start_r[3];

  qpms_pkg::out_item_t expected_q[$];
  int errors;
  int idle_cycles;
  bit hold_off;
  bit long_stall_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_sh(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_sat(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint scale_dt(longint a, longint b);
    longint hi;
    longint lo;
    hi = a >>> 16;
    lo = a - hi * 65536;
    return hi * b + ((lo * b + 32768) >>> 16);
  endfunction

  function automatic int atan_step(int i);
    int tab[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tab[i];
  endfunction

  function automatic longint trig_q14(longint v);
    v = round_sh(v, 10);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  task automatic sin_cos_of(input logic [15:0] ang, output longint s, output longint c);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cs;
    longint sn;
    logic [15:0] a;
    logic [15:0] r;
    int q;
    x = 10187910;
    y = 0;
    a = ang & qpms_pkg::ANGLE_MASK;
    q = ((32'(a) + 8192) >> 14) & 3;
    r = a - 16'(q * 16384);
    z = longint'($signed(r));
    for (int i = 0; i < 16; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    cs = trig_q14(x);
    sn = trig_q14(y);
    case (q)
      0: begin c = cs; s = sn; end
      1: begin c = -sn; s = cs; end
      2: begin c = -cs; s = -sn; end
      default: begin c = sn; s = -cs; end
    endcase
  endtask

  task automatic predict_tick(input qpms_pkg::in_item_t it, output qpms_pkg::out_item_t r);
    longint sr, cr, sp, cp, sy, cy, tx, ty, tz, a;
    longint acc[3];
    bit ground;
    ground = 1'b0;
    if (it.restart) begin
      for (int i = 0; i < 3; i++) begin
        pos_st[i] = clamp_sat(start_r[i], qpms_pkg::STATE_WIDTH);
        vel_st[i] = 0;
      end
    end else begin
      sin_cos_of(it.roll_angle, sr, cr);
      sin_cos_of(it.pitch_angle, sp, cp);
      sin_cos_of(it.yaw_angle, sy, cy);
      tx = round_sh(cy * sp * cr + sy * sr * 16384, 28);
      ty = round_sh(sy * sp * cr - cy * sr * 16384, 28);
      tz = round_sh(cp * cr, 14);
      a = round_sh(longint'(it.throttle) * accel_r, 14);
      acc[0] = round_sh(a * tx, 14);
      acc[1] = round_sh(a * ty, 14);
      acc[2] = round_sh(a * tz, 14) - grav_r;
      if (pos_st[2] <= 0 && acc[2] <= 0) begin
        pos_st[2] = 0;
        ground = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          vel_st[i] = clamp_sat(vel_st[i] + scale_dt(acc[i], dt_r), qpms_pkg::STATE_WIDTH);
          pos_st[i] = clamp_sat(pos_st[i] + scale_dt(vel_st[i], dt_r), qpms_pkg::STATE_WIDTH);
        end
      end
    end
    r.pos_x = 32'(clamp_sat(pos_st[0], 32));
    r.pos_y = 32'(clamp_sat(pos_st[1], 32));
    r.pos_z = 32'(clamp_sat(pos_st[2], 32));
    r.vel_x = 32'(clamp_sat(vel_st[0], 32));
    r.vel_y = 32'(clamp_sat(vel_st[1], 32));
    r.vel_z = 32'(clamp_sat(vel_st[2], 32));
    r.on_ground = ground;
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = 3'(idx);
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      qpms_pkg::CFG_GRAVITY: grav_r = longint'(val[22:0]);
      qpms_pkg::CFG_TIME_STEP: dt_r = longint'(val[16:0]);
      qpms_pkg::CFG_ACCEL: accel_r = longint'(val[24:0]);
      qpms_pkg::CFG_START_X: start_r[0] = longint'($signed(val));
      qpms_pkg::CFG_START_Y: start_r[1] = longint'($signed(val));
      default: start_r[2] = longint'($signed(val));
    endcase
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic send_tick(input qpms_pkg::in_item_t it, input bit gaps);
    qpms_pkg::out_item_t r;
    if (gaps) repeat ($urandom_range(0, 6)) @(negedge clk);
    in_valid = 1'b1;
    in_item = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(it, r);
    expected_q.push_back(r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic qpms_pkg::in_item_t mk(logic signed [15:0] thr, logic [15:0] ro,
                                            logic [15:0] pi, logic [15:0] ya, bit rs);
    qpms_pkg::in_item_t it;
    it.throttle = thr;
    it.roll_angle = ro;
    it.pitch_angle = pi;
    it.yaw_angle = ya;
    it.restart = rs;
    return it;
  endfunction

  function automatic qpms_pkg::in_item_t rand_tick();
    qpms_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.restart = (sel < 4);
    if (sel < 70) it.throttle = 16'($urandom_range(9000, 16384));
    else if (sel < 90) it.throttle = 16'(int'($urandom_range(0, 32768)) - 16384);
    else it.throttle = 16'($urandom);
    if (sel < 60) begin
      it.roll_angle = 16'(int'($urandom_range(0, 4000)) - 2000);
      it.pitch_angle = 16'(int'($urandom_range(0, 4000)) - 2000);
    end else begin
      it.roll_angle = 16'($urandom);
      it.pitch_angle = 16'($urandom);
    end
    it.yaw_angle = 16'($urandom);
    return it;
  endfunction

  // Directed rows: expected result given where obvious, else predictor-checked.
  typedef struct {
    qpms_pkg::in_item_t it;
    bit has_exp;
    qpms_pkg::out_item_t exp_val;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    qpms_pkg::out_item_t zero_res;
    qpms_pkg::out_item_t g;
    errors = 0;
    hold_off = 1'b0;
    long_stall_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 3; i++) begin
      pos_st[i] = 0; vel_st[i] = 0; start_r[i] = 0;
    end
    grav_r = 642253; dt_r = 1311; accel_r = 3211264;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    zero_res = '0;
    g = zero_res;
    g.on_ground = 1'b1;
    row.has_exp = 1'b1; row.exp_val = g;
    row.it = mk(16'sd0, 16'd0, 16'd0, 16'd0, 1'b0); rows.push_back(row);
    row.it = mk(-16'sd16384, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0); rows.push_back(row);
    row.exp_val = zero_res;
    row.it = mk(16'sd0, 16'd0, 16'd0, 16'd0, 1'b1); rows.push_back(row);
    row.has_exp = 1'b0;
    row.it = mk(16'sd16384, 16'd0, 16'd0, 16'd0, 1'b0); rows.push_back(row);
    row.it = mk(16'sd16384, 16'd16384, 16'd0, 16'd0, 1'b0); rows.push_back(row);
    row.it = mk(16'sd16384, 16'd0, 16'd32768, 16'd0, 1'b0); rows.push_back(row);
    row.it = mk(16'sd16384, 16'd8192, 16'd8191, 16'd49152, 1'b0); rows.push_back(row);
    row.it = mk(16'sh7FFF, 16'd1000, 16'd65000, 16'd24576, 1'b0); rows.push_back(row);
    row.it = mk(16'sh8000, 16'd0, 16'd0, 16'd40960, 1'b0); rows.push_back(row);
    row.it = mk(16'sd16384, 16'd57344, 16'd1, 16'd12345, 1'b0); rows.push_back(row);
    row.it = mk(-16'sd1, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b1); rows.push_back(row);
    for (int i = 0; i < rows.size(); i++) begin
      send_tick(rows[i].it, 1'b1);
      if (rows[i].has_exp) expected_q[$] = rows[i].exp_val;
    end
    wait_drained();

    // Extreme settings: max thrust and step, far start, then unit step, zero thrust and zero gravity.
    write_reg(qpms_pkg::CFG_ACCEL, 32'd16777216);
    write_reg(qpms_pkg::CFG_TIME_STEP, 32'd65536);
    write_reg(qpms_pkg::CFG_GRAVITY, 32'd4194304);
    write_reg(qpms_pkg::CFG_START_X, 32'h7FFFFFFF);
    write_reg(qpms_pkg::CFG_START_Y, 32'h80000000);
    write_reg(qpms_pkg::CFG_START_Z, 32'h7FFFFFFF);
    send_tick(mk(16'sd0, 16'd0, 16'd0, 16'd0, 1'b1), 1'b0);
    for (int i = 0; i < 30; i++) send_tick(rand_tick(), 1'b1);
    wait_drained();
    write_reg(qpms_pkg::CFG_GRAVITY, 32'd0);
    write_reg(qpms_pkg::CFG_TIME_STEP, 32'd1);
    write_reg(qpms_pkg::CFG_ACCEL, 32'd0);
    write_reg(qpms_pkg::CFG_START_Z, 32'h80000000);
    send_tick(mk(16'sd0, 16'd0, 16'd0, 16'd0, 1'b1), 1'b0);
    for (int i = 0; i < 30; i++) send_tick(rand_tick(), 1'b1);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(qpms_pkg::CFG_GRAVITY, $urandom_range(0, 4194304));
      write_reg(qpms_pkg::CFG_TIME_STEP, $urandom_range(1, 65536));
      write_reg(qpms_pkg::CFG_ACCEL, $urandom_range(0, 16777216));
      write_reg(qpms_pkg::CFG_START_X, $urandom);
      write_reg(qpms_pkg::CFG_START_Y, $urandom);
      write_reg(qpms_pkg::CFG_START_Z, (ph % 2) ? $urandom : $urandom_range(0, 655360));
      if (ph == 5) begin
        write_reg(qpms_pkg::CFG_GRAVITY, 32'd642253);
        write_reg(qpms_pkg::CFG_TIME_STEP, 32'd1311);
        write_reg(qpms_pkg::CFG_ACCEL, 32'd3211264);
      end
      send_tick(mk(16'sd0, 16'd0, 16'd0, 16'd0, 1'b1), 1'b0);
      for (int i = 0; i < NUM_RANDOM / 6; i++) begin
        if (ph == 2 && i == 20) long_stall_req = 1'b1;
        send_tick(rand_tick(), (i % 80) < 50);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    qpms_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.pos_x !== e.pos_x || out_item.pos_y !== e.pos_y ||
            out_item.pos_z !== e.pos_z || out_item.vel_x !== e.vel_x ||
            out_item.vel_y !== e.vel_y || out_item.vel_z !== e.vel_z ||
            out_item.on_ground !== e.on_ground) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, e, out_item);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we ||
        (!in_valid && expected_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
